[rtl/bprm_pkg.sv]
// Package for the block peak and RMS level meter.
// Holds widths, iteration counts, the controller state type and the
// command and status structs shared by the controller and the datapath.
package bprm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PEAK_W     = 15;
    localparam int RMS_W      = 23;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 40;
    localparam int SCALE_W    = 16;               // two times 8 fraction bits
    localparam int WORK_W     = SUM_W + SCALE_W;  // scaled mean square
    localparam int ROOT_W     = WORK_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int DIV_STEPS  = WORK_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } bprm_state_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic load;
        logic div_step;
        logic sqrt_step;
        logic publish;
    } bprm_cmd_t;

    typedef struct packed {
        logic close;
        logic out_free;
    } bprm_status_t;

endpackage

[rtl/bprm_ctrl.sv]
// Controller of the block peak and RMS level meter.
// Sequences capture, accumulation, the shared divide and square root
// iterations and the result handoff. Depends on bprm_pkg.
module bprm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bprm_pkg::bprm_status_t status,
    output bprm_pkg::bprm_cmd_t    cmd
);
    import bprm_pkg::*;

    bprm_state_t         state_reg;
    bprm_state_t         state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                div_end;
    logic                sqrt_end;

    assign div_end  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign sqrt_end = (step_reg == STEP_W'(SQRT_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = status.close ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_end)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One counter serves both iteration phases.
    always_comb
    begin
        step_next = '0;
        case (state_reg)
            ST_DIV:
            begin
                step_next = div_end ? '0 : step_reg + 1'b1;
            end
            ST_SQRT:
            begin
                step_next = sqrt_end ? '0 : step_reg + 1'b1;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/bprm_datapath.sv]
// Datapath of the block peak and RMS level meter.
// Magnitude, peak, saturating square sum, frame counter, a restoring
// divider and a digit-by-digit square root. Depends on bprm_pkg.
module bprm_datapath #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [bprm_pkg::SAMPLE_W-1:0] sample,
    input  logic                              last,
    input  bprm_pkg::bprm_cmd_t               cmd,
    output bprm_pkg::bprm_status_t            status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bprm_pkg::PEAK_W-1:0]       peak,
    output logic [bprm_pkg::RMS_W-1:0]        rms,
    output logic [bprm_pkg::COUNT_W-1:0]      frame_count
);
    import bprm_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [PEAK_W-1:0]     mag;
    logic [PEAK_W-1:0]     mag_reg;
    logic                  last_reg;
    logic [PEAK_W-1:0]     peak_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      frames_reg;
    logic [CNT_W-1:0]      frames_inc;
    logic [2*PEAK_W-1:0]   square;
    logic [SUM_W:0]        sum_add;
    logic [CNT_W+COUNT_W-1:0] frames_wide;

    logic [WORK_W-1:0]     work_reg;
    logic [CNT_W-1:0]      divisor_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W:0]        rem_sh;
    logic                  div_ge;
    logic [SQ_REM_W-1:0]   sq_rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQ_REM_W+1:0]   sq_sh;
    logic [SQ_REM_W+1:0]   trial;
    logic                  sqrt_ge;

    logic [PEAK_W-1:0]     res_peak_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic                  out_valid_reg;
    logic [PEAK_W-1:0]     peak_out_reg;
    logic [RMS_W-1:0]      rms_out_reg;
    logic [COUNT_W-1:0]    count_out_reg;

    // The most negative sample saturates instead of wrapping.
    always_comb
    begin
        if (!sample[SAMPLE_W-1])
        begin
            mag = sample[PEAK_W-1:0];
        end
        else if (sample[PEAK_W-1:0] == '0)
        begin
            mag = '1;
        end
        else
        begin
            mag = PEAK_W'(-sample);
        end
    end

    assign square      = (2*PEAK_W)'(mag_reg) * (2*PEAK_W)'(mag_reg);
    assign sum_add     = {1'b0, sum_reg} + (SUM_W + 1)'(square);
    assign frames_inc  = frames_reg + 1'b1;
    assign frames_wide = {{COUNT_W{1'b0}}, frames_reg};

    assign status.close    = last_reg || (frames_inc == CNT_W'(MAX_FRAMES));
    assign status.out_free = !out_valid_reg || out_ready;

    assign rem_sh  = {rem_reg, work_reg[WORK_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, divisor_reg});
    assign sq_sh   = {sq_rem_reg, work_reg[WORK_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sqrt_ge = (sq_sh >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg  <= mag;
            last_reg <= last;
        end
    end

    // Running state of the open block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            sum_reg    <= '0;
            frames_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (mag_reg > peak_reg)
            begin
                peak_reg <= mag_reg;
            end
            sum_reg    <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            frames_reg <= frames_inc;
        end
        else if (cmd.load)
        begin
            peak_reg   <= '0;
            sum_reg    <= '0;
            frames_reg <= '0;
        end
    end

    // The work register holds the dividend, then the quotient that the
    // square root consumes two bits at a time.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg      <= {sum_reg, {SCALE_W{1'b0}}};
            divisor_reg   <= frames_reg;
            rem_reg       <= '0;
            sq_rem_reg    <= '0;
            root_reg      <= '0;
            res_peak_reg  <= peak_reg;
            res_count_reg <= frames_wide[COUNT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? CNT_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[CNT_W-1:0];
            work_reg <= {work_reg[WORK_W-2:0], div_ge};
        end
        else if (cmd.sqrt_step)
        begin
            sq_rem_reg <= sqrt_ge ? SQ_REM_W'(sq_sh - trial) : sq_sh[SQ_REM_W-1:0];
            root_reg   <= {root_reg[ROOT_W-2:0], sqrt_ge};
            work_reg   <= {work_reg[WORK_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            peak_out_reg  <= res_peak_reg;
            rms_out_reg   <= root_reg[RMS_W-1:0];
            count_out_reg <= res_count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign peak        = peak_out_reg;
    assign rms         = rms_out_reg;
    assign frame_count = count_out_reg;

endmodule

[rtl/block_peak_rms_meter.sv]
// Block peak and RMS level meter, top level.
// Joins the controller and the datapath. Depends on bprm_pkg, bprm_ctrl
// and bprm_datapath.
//
// Usage: signed 16-bit samples enter on the in channel (in_valid,
// in_ready, sample, last). Each item is first captured, then the peak,
// the square sum and the frame count are updated; no new item is taken
// until the update of the previous one is done.
// An item marked last, or the one that brings the count to MAX_FRAMES,
// closes the block. A closing item then passes through a load step, a
// one-bit-per-cycle divider that forms the scaled mean square, a
// two-bits-per-cycle square root and a step that hands the result to
// the output register. The result becomes valid in the same cycle in
// which the input is ready for the next item.
// Results leave on the out channel (out_valid, out_ready, peak, rms,
// frame_count). The output register holds a result until it is taken; if
// the receiver stalls, a finished block waits in the datapath and input
// stops until the output register frees.
// Reset clears the peak, the square sum, the frame count and all handshake
// state; no result is pending after reset.
module block_peak_rms_meter #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [bprm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bprm_pkg::PEAK_W-1:0]           peak,
    output logic [bprm_pkg::RMS_W-1:0]            rms,
    output logic [bprm_pkg::COUNT_W-1:0]          frame_count
);
    import bprm_pkg::*;

    bprm_cmd_t    cmd;
    bprm_status_t status;

    bprm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bprm_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .peak        (peak),
        .rms         (rms),
        .frame_count (frame_count)
    );

endmodule
